// ===== rtl/cts_pkg.sv =====
// Shared types and constants of the cooperative task scheduler.
// No dependencies; the top, the slot unit and the bench refer to it by scoped names.
package cts_pkg;

    localparam int RESULT_CAP   = 16;
    localparam int COUNT_W      = $clog2(RESULT_CAP + 1);
    localparam int HOLD_W       = 16;
    localparam logic [HOLD_W-1:0] HOLD_DISPATCHES = 16'd60000;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_DEL  = 2'd2,
        MODE_DISP = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_DONE  = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_DUE   = 3'd3,
        ST_NONE  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_FULL = 2'd1,
        ERR_DEL  = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ADD,
        S_FLUSH
    } t_state;

    // One table entry as held in the slot RAM.
    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  runs;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result of the shared slot update unit.
    typedef struct packed {
        t_entry entry;
        logic   due;
        logic   release_slot;
    } t_alu_res;

    // One pending result.
    typedef struct packed {
        t_status    status;
        logic [3:0] slot;
        logic [7:0] tag;
    } t_result;

endpackage

// ===== rtl/cooperative_task_scheduler_top.sv =====
// Top level of the time-triggered cooperative task scheduler: sequencer, error aging, output.
// Depends on cts_pkg, cts_ram and cts_slot_alu.
//
//  channel   direction  handshake                    payload
//  request   in         i_req_valid / o_req_ready    i_mode, i_task_tag, i_start_delay,
//                                                    i_repeat_period, i_slot_index
//  result    out        o_rsp_valid / i_rsp_ready    o_status, o_slot, o_tag_out,
//                                                    o_error_state, o_last_result
//
// Walks: a tick or dispatch request walks the slot RAM one slot a cycle through the shared
// slot unit unless a dispatch is stalled; a dispatch stops early after its sixteenth due
// slot. An add walks the used bits until the first free slot.
// One request is in work at a time.
// Reset clears the used bits at once; RAM contents of unused slots read as zero, so there is
// no clearing pass. A stalled result port holds a dispatch walk at its next due slot.
module cooperative_task_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_task_tag,
    input  logic [15:0] i_start_delay,
    input  logic [15:0] i_repeat_period,
    input  logic [3:0]  i_slot_index,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [7:0]  o_tag_out,
    output logic [1:0]  o_error_state,
    output logic        o_last_result
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TASKS - 1);
    localparam logic [cts_pkg::COUNT_W-1:0] CAP_LAST =
        cts_pkg::COUNT_W'(cts_pkg::RESULT_CAP - 1);

    // Sequencer state
    cts_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_p, n_p;
    logic [cts_pkg::COUNT_W-1:0] r_count, n_count;
    logic [MAX_TASKS-1:0] r_used, n_used;

    // Latched request
    cts_pkg::t_mode   r_mode, n_mode;
    logic [7:0]       r_tag, n_tag;
    logic [15:0]      r_dly, n_dly;
    logic [15:0]      r_per, n_per;

    // Held result, waiting for the next due slot or the end of the walk
    cts_pkg::t_result r_pend, n_pend;
    logic             r_pend_v, n_pend_v;

    // Error aging
    logic [1:0]                  r_err_now, n_err_now;
    logic [1:0]                  r_err_seen, n_err_seen;
    logic [cts_pkg::HOLD_W-1:0]  r_err_hold, n_err_hold;

    // Output register
    logic             r_o_valid, n_o_valid;
    cts_pkg::t_result r_o_res, n_o_res;
    logic [1:0]       r_o_err, n_o_err;
    logic             r_o_last, n_o_last;

    // RAM and slot unit
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    cts_pkg::t_entry  ram_wdata, ram_rdata, cur_entry;
    cts_pkg::t_alu_res alu;

    logic accept, out_free, last_slot, is_disp, stall;
    logic [3:0] p_slot;
    logic [AW-1:0] del_idx;
    logic del_ok;
    logic [31:0] p_wide, idx_wide;

    assign accept    = i_req_valid && o_req_ready;
    assign out_free  = !r_o_valid || i_rsp_ready;
    assign last_slot = (r_p == LAST_SLOT);
    assign is_disp   = (r_mode == cts_pkg::MODE_DISP);
    assign p_wide    = 32'(r_p);
    assign p_slot    = p_wide[3:0];
    assign idx_wide  = 32'(i_slot_index);
    assign del_idx   = idx_wide[AW-1:0];
    assign del_ok    = (idx_wide < 32'(MAX_TASKS)) && r_used[del_idx];

    assign cur_entry = r_used[r_p] ? ram_rdata : '0;

    // Hold the walk while a due slot cannot push the previous result out.
    assign stall = (r_state == cts_pkg::S_SCAN) && is_disp && alu.due && r_pend_v && !out_free;

    // Read ahead by one slot; re-read the current slot when stalled or on the last slot.
    always_comb begin
        if (r_state != cts_pkg::S_SCAN) begin
            ram_raddr = '0;
        end else if (stall || last_slot) begin
            ram_raddr = r_p;
        end else begin
            ram_raddr = r_p + AW'(1);
        end
    end

    cts_ram #(
        .WIDTH (cts_pkg::ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cts_slot_alu u_slot_alu (
        .i_disp  (is_disp),
        .i_used  (r_used[r_p]),
        .i_entry (cur_entry),
        .o_res   (alu)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cts_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (cts_pkg::t_mode'(i_mode))
                        cts_pkg::MODE_ADD: n_state = cts_pkg::S_ADD;
                        cts_pkg::MODE_DEL: n_state = cts_pkg::S_FLUSH;
                        default:           n_state = cts_pkg::S_SCAN;
                    endcase
                end
            end
            cts_pkg::S_SCAN: begin
                if (is_disp) begin
                    if (!stall && ((alu.due && r_count == CAP_LAST) || last_slot)) begin
                        n_state = cts_pkg::S_FLUSH;
                    end
                end else if (last_slot) begin
                    n_state = cts_pkg::S_FLUSH;
                end
            end
            cts_pkg::S_ADD: begin
                if (!r_used[r_p] || last_slot) begin
                    n_state = cts_pkg::S_FLUSH;
                end
            end
            cts_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_state = cts_pkg::S_IDLE;
                end
            end
            default: n_state = cts_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_p        = r_p;
        n_count    = r_count;
        n_used     = r_used;
        n_mode     = r_mode;
        n_tag      = r_tag;
        n_dly      = r_dly;
        n_per      = r_per;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_err_now  = r_err_now;
        n_err_seen = r_err_seen;
        n_err_hold = r_err_hold;
        n_o_valid  = r_o_valid && !i_rsp_ready;
        n_o_res    = r_o_res;
        n_o_err    = r_o_err;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = r_p;
        ram_wdata  = alu.entry;

        unique case (r_state)
            cts_pkg::S_IDLE: begin
                if (accept) begin
                    n_mode   = cts_pkg::t_mode'(i_mode);
                    n_tag    = i_task_tag;
                    n_dly    = i_start_delay;
                    n_per    = i_repeat_period;
                    n_p      = '0;
                    n_count  = '0;
                    n_pend_v = 1'b0;
                    unique case (cts_pkg::t_mode'(i_mode))
                        cts_pkg::MODE_DEL: begin
                            n_pend_v = 1'b1;
                            n_pend.slot = i_slot_index;
                            n_pend.tag  = 8'd0;
                            if (del_ok) begin
                                n_used[del_idx] = 1'b0;
                                n_pend.status   = cts_pkg::ST_DONE;
                            end else begin
                                n_err_now     = cts_pkg::ERR_DEL;
                                n_pend.status = cts_pkg::ST_EMPTY;
                            end
                        end
                        cts_pkg::MODE_DISP: begin
                            // Aging does not depend on this dispatch, so apply it up front:
                            // every result of the dispatch carries the aged code.
                            if (r_err_now != r_err_seen) begin
                                n_err_seen = r_err_now;
                                n_err_hold = (r_err_now != cts_pkg::ERR_NONE) ?
                                             cts_pkg::HOLD_DISPATCHES : '0;
                            end else if (r_err_hold != '0) begin
                                n_err_hold = r_err_hold - cts_pkg::HOLD_W'(1);
                                if (r_err_hold == cts_pkg::HOLD_W'(1)) begin
                                    n_err_now = cts_pkg::ERR_NONE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            cts_pkg::S_SCAN: begin
                if (is_disp) begin
                    if (alu.due && !stall) begin
                        if (r_pend_v) begin
                            n_o_valid = 1'b1;
                            n_o_res   = r_pend;
                            n_o_err   = r_err_now;
                            n_o_last  = 1'b0;
                        end
                        n_pend.status = cts_pkg::ST_DUE;
                        n_pend.slot   = p_slot;
                        n_pend.tag    = cur_entry.tag;
                        n_pend_v      = 1'b1;
                        n_count       = r_count + cts_pkg::COUNT_W'(1);
                        ram_we        = 1'b1;
                        if (alu.release_slot) begin
                            n_used[r_p] = 1'b0;
                        end
                    end else if (!alu.due && last_slot && !r_pend_v) begin
                        n_pend.status = cts_pkg::ST_NONE;
                        n_pend.slot   = 4'd0;
                        n_pend.tag    = 8'd0;
                        n_pend_v      = 1'b1;
                    end
                end else begin
                    ram_we = r_used[r_p];
                    if (last_slot) begin
                        n_pend.status = cts_pkg::ST_DONE;
                        n_pend.slot   = 4'd0;
                        n_pend.tag    = 8'd0;
                        n_pend_v      = 1'b1;
                    end
                end
                if (!stall) begin
                    n_p = r_p + AW'(1);
                end
            end
            cts_pkg::S_ADD: begin
                n_pend.tag = 8'd0;
                if (!r_used[r_p]) begin
                    ram_we         = 1'b1;
                    ram_wdata.tag    = r_tag;
                    ram_wdata.delay  = r_dly;
                    ram_wdata.period = r_per;
                    ram_wdata.runs   = 8'd0;
                    n_used[r_p]    = 1'b1;
                    n_pend.status  = cts_pkg::ST_DONE;
                    n_pend.slot    = p_slot;
                    n_pend_v       = 1'b1;
                end else if (last_slot) begin
                    n_err_now     = cts_pkg::ERR_FULL;
                    n_pend.status = cts_pkg::ST_FULL;
                    n_pend.slot   = 4'd0;
                    n_pend_v      = 1'b1;
                end
                n_p = r_p + AW'(1);
            end
            cts_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_res   = r_pend;
                    n_o_err   = r_err_now;
                    n_o_last  = 1'b1;
                    n_pend_v  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cts_pkg::S_IDLE;
            r_used     <= '0;
            r_pend_v   <= 1'b0;
            r_err_now  <= cts_pkg::ERR_NONE;
            r_err_seen <= cts_pkg::ERR_NONE;
            r_err_hold <= '0;
            r_o_valid  <= 1'b0;
            r_p        <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_pend_v   <= n_pend_v;
            r_err_now  <= n_err_now;
            r_err_seen <= n_err_seen;
            r_err_hold <= n_err_hold;
            r_o_valid  <= n_o_valid;
            r_p        <= n_p;
            r_count    <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_tag    <= n_tag;
        r_dly    <= n_dly;
        r_per    <= n_per;
        r_pend   <= n_pend;
        r_o_res  <= n_o_res;
        r_o_err  <= n_o_err;
        r_o_last <= n_o_last;
    end

    assign o_req_ready   = (r_state == cts_pkg::S_IDLE);
    assign o_rsp_valid   = r_o_valid;
    assign o_status      = r_o_res.status;
    assign o_slot        = r_o_res.slot;
    assign o_tag_out     = r_o_res.tag;
    assign o_error_state = r_o_err;
    assign o_last_result = r_o_last;

    // The final flush always has a held result to deliver.
    a_flush_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cts_pkg::S_FLUSH |-> r_pend_v)
        else $error("flush without a held result");

    // A dispatch never serves more than the result cap.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cts_pkg::COUNT_W'(cts_pkg::RESULT_CAP))
        else $error("dispatch result count past cap");

    // A write-back during the walk never hits the slot being read ahead.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == cts_pkg::S_SCAN && !last_slot) |-> ram_raddr != ram_waddr)
        else $error("slot RAM read and write collide");

    // A stalled walk keeps its slot and its result count.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> ($stable(r_p) && $stable(r_count) && r_state == cts_pkg::S_SCAN))
        else $error("walk advanced during stall");

endmodule

// ===== rtl/cts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cts_slot_alu.sv =====
// Shared slot update unit: countdown and run counting for tick, run take-off for dispatch.
// Depends on cts_pkg.
module cts_slot_alu (
    input  logic              i_disp,
    input  logic              i_used,
    input  cts_pkg::t_entry   i_entry,
    output cts_pkg::t_alu_res o_res
);

    always_comb begin
        o_res.entry        = i_entry;
        o_res.due          = i_used && (i_entry.runs != 8'd0);
        o_res.release_slot = (i_entry.period == 16'd0);
        if (i_disp) begin
            o_res.entry.runs = i_entry.runs - 8'd1;
        end else if (i_entry.delay == 16'd0) begin
            // wrap past 255 is intended
            o_res.entry.runs  = i_entry.runs + 8'd1;
            o_res.entry.delay = i_entry.period;
        end else begin
            o_res.entry.delay = i_entry.delay - 16'd1;
        end
    end

endmodule

// ===== tb/tb_cooperative_task_scheduler_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for cooperative_task_scheduler_top: request driver, task table predictor
// and result scoreboard. Depends on cts_pkg and the scheduler RTL.
module tb;

    localparam int SLOTS            = 16;
    // One tick or dispatch walks every slot; allow a couple of walks once the queue drains.
    localparam int SETTLE_CYCLES    = 2 * SLOTS + 8;
    localparam int RANDOM_ITEMS     = 58;
    localparam int AGING_DISPATCHES = 4;

    // One predicted result, field for field as the result port carries it.
    typedef struct packed {
        cts_pkg::t_status status;
        logic [3:0]       slot;
        logic [7:0]       tag;
        cts_pkg::t_err    err;
        logic             last;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_ready;
    logic [1:0]  i_mode = cts_pkg::MODE_TICK;
    logic [7:0]  i_task_tag = '0;
    logic [15:0] i_start_delay = '0;
    logic [15:0] i_repeat_period = '0;
    logic [3:0]  i_slot_index = '0;
    logic        o_rsp_valid;
    logic        i_rsp_ready = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_slot;
    logic [7:0]  o_tag_out;
    logic [1:0]  o_error_state;
    logic        o_last_result;

    // Predicted task table and error aging, updated as each request is accepted.
    logic          tbl_used   [SLOTS] = '{default: 1'b0};
    logic [7:0]    tbl_tag    [SLOTS] = '{default: '0};
    logic [15:0]   tbl_delay  [SLOTS] = '{default: '0};
    logic [15:0]   tbl_period [SLOTS] = '{default: '0};
    logic [7:0]    tbl_runs   [SLOTS] = '{default: '0};
    cts_pkg::t_err held_err = cts_pkg::ERR_NONE;
    cts_pkg::t_err seen_err = cts_pkg::ERR_NONE;
    logic [15:0]   err_countdown = '0;

    t_outcome queued_outcomes[$];
    int       fail_count = 0;
    int       sender_idle_pct = 0;
    int       rsp_stall_pct = 0;
    int       hold_left = 0;

    always #2 i_clk = ~i_clk;

    cooperative_task_scheduler_top #(
        .MAX_TASKS(SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_mode         (i_mode),
        .i_task_tag     (i_task_tag),
        .i_start_delay  (i_start_delay),
        .i_repeat_period(i_repeat_period),
        .i_slot_index   (i_slot_index),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_tag_out      (o_tag_out),
        .o_error_state  (o_error_state),
        .o_last_result  (o_last_result)
    );

    function automatic t_outcome outcome(cts_pkg::t_status st, logic [3:0] sl, logic [7:0] tg);
        t_outcome o;
        o.status = st;
        o.slot   = sl;
        o.tag    = tg;
        o.err    = cts_pkg::ERR_NONE;
        o.last   = 1'b0;
        return o;
    endfunction

    function automatic void free_slot(int s);
        tbl_used[s]   = 1'b0;
        tbl_tag[s]    = '0;
        tbl_delay[s]  = '0;
        tbl_period[s] = '0;
        tbl_runs[s]   = '0;
    endfunction

    // Apply one accepted request to the predicted table and queue the results it causes.
    function automatic void run_table_request(cts_pkg::t_mode m, logic [7:0] tg,
                                              logic [15:0] dl, logic [15:0] pr,
                                              logic [3:0] ix);
        t_outcome batch[$];
        int       s;
        case (m)
            cts_pkg::MODE_TICK: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (!tbl_used[s]) continue;
                    if (tbl_delay[s] == 0) begin
                        // runs is 8 bits wide, so 255 wraps to 0
                        tbl_runs[s]  = tbl_runs[s] + 8'd1;
                        tbl_delay[s] = tbl_period[s];
                    end else begin
                        tbl_delay[s] = tbl_delay[s] - 16'd1;
                    end
                end
                batch.push_back(outcome(cts_pkg::ST_DONE, '0, '0));
            end
            cts_pkg::MODE_ADD: begin
                s = 0;
                while (s < SLOTS && tbl_used[s]) s++;
                if (s == SLOTS) begin
                    held_err = cts_pkg::ERR_FULL;
                    batch.push_back(outcome(cts_pkg::ST_FULL, '0, '0));
                end else begin
                    tbl_used[s]   = 1'b1;
                    tbl_tag[s]    = tg;
                    tbl_delay[s]  = dl;
                    tbl_period[s] = pr;
                    tbl_runs[s]   = '0;
                    batch.push_back(outcome(cts_pkg::ST_DONE, 4'(s), '0));
                end
            end
            cts_pkg::MODE_DEL: begin
                if (!tbl_used[ix]) begin
                    held_err = cts_pkg::ERR_DEL;
                    batch.push_back(outcome(cts_pkg::ST_EMPTY, ix, '0));
                end else begin
                    free_slot(ix);
                    batch.push_back(outcome(cts_pkg::ST_DONE, ix, '0));
                end
            end
            default: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (tbl_runs[s] == 0 || batch.size() >= cts_pkg::RESULT_CAP) continue;
                    batch.push_back(outcome(cts_pkg::ST_DUE, 4'(s), tbl_tag[s]));
                    tbl_runs[s] = tbl_runs[s] - 8'd1;
                    // a one-shot leaves the table once it has run
                    if (tbl_period[s] == 0) free_slot(s);
                end
                if (batch.size() == 0) batch.push_back(outcome(cts_pkg::ST_NONE, '0, '0));
                // age the held error once per dispatch
                if (held_err != seen_err) begin
                    seen_err      = held_err;
                    err_countdown = (held_err != cts_pkg::ERR_NONE) ?
                                    cts_pkg::HOLD_DISPATCHES : '0;
                end else if (err_countdown != 0) begin
                    err_countdown = err_countdown - 16'd1;
                    if (err_countdown == 0) held_err = cts_pkg::ERR_NONE;
                end
            end
        endcase
        // every result carries the error as it stands after the whole request
        foreach (batch[k]) begin
            batch[k].err  = held_err;
            batch[k].last = (k == batch.size() - 1);
            queued_outcomes.push_back(batch[k]);
        end
    endfunction

    // Offer one request after a random gap and hold it until accepted. Call right after a
    // rising edge; leave valid high so the next request follows without a gap.
    task automatic send_request(cts_pkg::t_mode m, logic [7:0] tg, logic [15:0] dl,
                                logic [15:0] pr, logic [3:0] ix);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid     <= 1'b1;
        i_mode          <= m;
        i_task_tag      <= tg;
        i_start_delay   <= dl;
        i_repeat_period <= pr;
        i_slot_index    <= ix;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        run_table_request(m, tg, dl, pr, ix);
    endtask

    // Mostly short delays and periods so tasks fall due often; now and then the full range.
    function automatic logic [15:0] pick_ticks(int hi);
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(hi));
    endfunction

    task automatic send_random_request();
        int         pick;
        int         busy[$];
        logic [3:0] ix;
        pick = $urandom_range(99);
        ix   = 4'($urandom_range(SLOTS - 1));
        if (pick < 35) begin
            send_request(cts_pkg::MODE_TICK, 8'($urandom), 16'($urandom), 16'($urandom), ix);
        end else if (pick < 60) begin
            send_request(cts_pkg::MODE_ADD, 8'($urandom), pick_ticks(6), pick_ticks(5), ix);
        end else if (pick < 80) begin
            send_request(cts_pkg::MODE_DISP, 8'($urandom), 16'($urandom), 16'($urandom), ix);
        end else begin
            for (int s = 0; s < SLOTS; s++) if (tbl_used[s]) busy.push_back(s);
            // mostly drop a live task; sometimes aim at whatever slot, empty or not
            if (busy.size() != 0 && $urandom_range(4) != 0)
                ix = 4'(busy[$urandom_range(busy.size() - 1)]);
            send_request(cts_pkg::MODE_DEL, 8'($urandom), 16'($urandom), 16'($urandom), ix);
        end
    endtask

    task automatic clear_table();
        for (int s = 0; s < SLOTS; s++)
            if (tbl_used[s])
                send_request(cts_pkg::MODE_DEL, 8'($urandom), 16'($urandom), 16'($urandom),
                             4'(s));
    endtask

    // Empty table: nothing due, tick with no tasks, delete of empty slots at both ends.
    task automatic test_empty_table();
        send_request(cts_pkg::MODE_DISP, 8'hA5, 16'h1234, 16'h4321, 4'd7);
        send_request(cts_pkg::MODE_TICK, 8'h5A, 16'hFFFF, 16'hFFFF, 4'd15);
        send_request(cts_pkg::MODE_DEL, 8'h00, 16'h0000, 16'h0000, 4'd0);
        send_request(cts_pkg::MODE_DEL, 8'hFF, 16'hFFFF, 16'hFFFF, 4'd15);
        send_request(cts_pkg::MODE_DISP, 8'h00, 16'h0000, 16'h0000, 4'd0);
    endtask

    // Fill every slot with extreme tags, delays and periods, overflow the table, then serve.
    task automatic test_fill_and_serve();
        for (int s = 0; s < SLOTS; s++)
            send_request(cts_pkg::MODE_ADD, 8'(s * 17), (s < 8) ? 16'h0000 : 16'hFFFF,
                         (s < 4) ? 16'h0000 : ((s < 8) ? 16'h0001 : 16'hFFFF), 4'(s));
        send_request(cts_pkg::MODE_ADD, 8'h3C, 16'h0000, 16'h0000, 4'd0);
        // one-shots stay at zero and gain a run on every tick until served
        repeat (3) send_request(cts_pkg::MODE_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0);
        send_request(cts_pkg::MODE_DISP, 8'h00, 16'h0000, 16'h0000, 4'd0);
        send_request(cts_pkg::MODE_DEL, 8'h00, 16'h0000, 16'h0000, 4'd0);
        send_request(cts_pkg::MODE_DEL, 8'h00, 16'h0000, 16'h0000, 4'd15);
        send_request(cts_pkg::MODE_ADD, 8'h81, 16'h0000, 16'h0002, 4'd0);
        send_request(cts_pkg::MODE_DISP, 8'h00, 16'h0000, 16'h0000, 4'd0);
    endtask

    // Every slot due at once: one dispatch gives the full sixteen results.
    task automatic test_all_slots_due();
        clear_table();
        for (int s = 0; s < SLOTS; s++)
            send_request(cts_pkg::MODE_ADD, 8'($urandom), 16'h0000, 16'h0003, 4'(s));
        send_request(cts_pkg::MODE_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0);
        send_request(cts_pkg::MODE_DISP, 8'h00, 16'h0000, 16'h0000, 4'd0);
        send_request(cts_pkg::MODE_DISP, 8'h00, 16'h0000, 16'h0000, 4'd0);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct);
        sender_idle_pct = idle_pct;
        rsp_stall_pct   = stall_pct;
        repeat (RANDOM_ITEMS) send_random_request();
    endtask

    // Hold off the result port for a long stretch while requests keep coming, so the block
    // fills up and drops its request ready.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        rsp_stall_pct   = 0;
        hold_left       = 400;
        repeat (40) send_random_request();
    endtask

    // Sticky error: raise it, then check that it stays held while a few dispatches count
    // its hold down.
    task automatic test_error_aging();
        sender_idle_pct = 0;
        rsp_stall_pct   = 0;
        clear_table();
        send_request(cts_pkg::MODE_DEL, 8'h00, 16'h0000, 16'h0000, 4'd5);
        repeat (AGING_DISPATCHES)
            send_request(cts_pkg::MODE_DISP, 8'($urandom), 16'($urandom), 16'($urandom),
                         4'($urandom));
        send_request(cts_pkg::MODE_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0);
    endtask

    // Drive result ready: a counted hold-off when one is pending, random stalls otherwise.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_rsp_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    // Match each accepted result against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (queued_outcomes.size() == 0) begin
                fail_count++;
                $error("unexpected result: status %0d slot %0d tag %0d",
                       o_status, o_slot, o_tag_out);
            end else begin
                want = queued_outcomes.pop_front();
                check_field("status", 8'(want.status), 8'(o_status));
                check_field("slot", 8'(want.slot), 8'(o_slot));
                check_field("tag_out", want.tag, o_tag_out);
                check_field("error_state", 8'(want.err), 8'(o_error_state));
                check_field("last_result", 8'(want.last), 8'(o_last_result));
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_fill_and_serve();
        test_all_slots_due();
        test_random_traffic(0, 0);
        test_random_traffic(77, 0);
        test_random_traffic(0, 77);
        test_random_traffic(25, 25);
        test_backpressure();
        test_error_aging();

        // drop valid, drain the outstanding results, then watch for strays
        i_req_valid <= 1'b0;
        while (queued_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("cooperative_task_scheduler_top verification clean");
        else
            $display("cooperative_task_scheduler_top verification failed");
        $finish;
    end

    // Watchdog: about 350 requests of at most sixteen stalled results each, plus the long
    // hold-off, stay well under a tenth of this.
    initial begin
        #2_000_000;
        $display("cooperative_task_scheduler_top verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cts_pkg.sv
rtl/cts_ram.sv
rtl/cts_slot_alu.sv
rtl/cooperative_task_scheduler_top.sv
tb/tb_cooperative_task_scheduler_top.sv
